[rtl/core/hue_color_classifier_core_macros.svh]
// Assertion macros shared by the hue color classifier core.
`ifndef HUE_COLOR_CLASSIFIER_CORE_MACROS_SVH
`define HUE_COLOR_CLASSIFIER_CORE_MACROS_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define HCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The condition must hold at every clock edge outside reset.
`define HCC_ASSERT_ALWAYS(lbl, cond, msg) \
  `HCC_ASSERT_IMP(lbl, 1'b1, cond, msg)

`endif

[rtl/core/hcc_pkg.sv]
// Types, constants and tables of the hue color classifier core.
`timescale 1ns / 1ps
package hcc_pkg;

  localparam int unsigned CordicStages = 8;
  localparam int unsigned Latency      = 14;

  localparam logic signed [19:0] HalfPiQ16 = 20'sd102944;
  localparam logic signed [19:0] PiQ16     = 20'sd205887;
  localparam logic signed [19:0] TwoPiQ16  = 20'sd411775;

  localparam logic [2:0] RegTargetRed    = 3'd0;
  localparam logic [2:0] RegTargetGreen  = 3'd1;
  localparam logic [2:0] RegTargetBlue   = 3'd2;
  localparam logic [2:0] RegTargetYellow = 3'd3;
  localparam logic [2:0] RegHueRadius    = 3'd4;
  localparam logic [2:0] RegMinBright    = 3'd5;
  localparam logic [2:0] RegMinSpread    = 3'd6;

  typedef enum logic [2:0] {
    ClassNone   = 3'd0,
    ClassRed    = 3'd1,
    ClassGreen  = 3'd2,
    ClassBlue   = 3'd3,
    ClassYellow = 3'd4
  } color_class_e;

  typedef struct packed {
    logic signed [28:0] x;
    logic signed [28:0] y;
    logic signed [19:0] z;
  } cordic_t;

  typedef struct packed {
    logic valid;
    logic pix_ok;
    logic grey;
    logic u_neg;
    logic wd_pos;
  } side_t;

  typedef struct packed {
    logic [7:0] target_red;
    logic [7:0] target_green;
    logic [7:0] target_blue;
    logic [7:0] target_yellow;
    logic [7:0] radius;
  } match_cfg_t;

  function automatic logic signed [19:0] atan_q16(input int unsigned step);
    logic signed [19:0] v;
    case (step)
      0:       v = 20'sd51472;
      1:       v = 20'sd30385;
      2:       v = 20'sd16055;
      3:       v = 20'sd8150;
      4:       v = 20'sd4091;
      5:       v = 20'sd2047;
      6:       v = 20'sd1024;
      7:       v = 20'sd512;
      8:       v = 20'sd256;
      9:       v = 20'sd128;
      10:      v = 20'sd64;
      11:      v = 20'sd32;
      12:      v = 20'sd16;
      13:      v = 20'sd8;
      14:      v = 20'sd4;
      15:      v = 20'sd2;
      default: v = 20'sd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/core/hcc_prep.sv]
// Front stages: brightness, spread check and CORDIC start vector.
`timescale 1ns / 1ps
module hcc_prep import hcc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  input  logic [7:0] min_bright_i,
  input  logic [7:0] min_spread_i,
  output cordic_t    vec_o,
  output side_t      side_o
);

  logic [9:0]  sum;
  logic [20:0] mean_prod;
  logic [7:0]  mean;
  logic signed [10:0] u;
  logic signed [8:0]  wd;
  logic signed [28:0] x_raw;
  logic signed [28:0] y_raw;
  cordic_t vec1_d;

  logic        valid1_q;
  logic [7:0]  mean1_q, red1_q, green1_q, blue1_q;
  cordic_t     vec1_q;
  logic        grey1_q, u_neg1_q, wd_pos1_q;

  logic [7:0]  dev_r, dev_g, dev_b;
  logic [9:0]  dev_sum;
  logic [20:0] spread_prod;
  logic [7:0]  spread;

  logic        valid2_q, pix_ok2_q, grey2_q, u_neg2_q, wd_pos2_q;
  cordic_t     vec2_q;

  always_comb begin
    sum       = 10'(red_i) + 10'(green_i) + 10'(blue_i);
    mean_prod = 21'(sum) * 21'd683;
    mean      = mean_prod[18:11];
    u         = $signed({3'b000, red_i} << 1) - $signed({3'b000, green_i})
                - $signed({3'b000, blue_i});
    wd        = $signed({1'b0, blue_i}) - $signed({1'b0, green_i});
    x_raw     = 29'(u) <<< 16;
    y_raw     = 29'(wd) * 29'sd113512;
    vec1_d.x  = x_raw;
    vec1_d.y  = y_raw;
    vec1_d.z  = '0;
    if (u < 0) begin
      if (wd > 0) begin
        vec1_d.x = y_raw;
        vec1_d.y = -x_raw;
        vec1_d.z = HalfPiQ16;
      end else begin
        vec1_d.x = -y_raw;
        vec1_d.y = x_raw;
        vec1_d.z = -HalfPiQ16;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mean1_q   <= mean;
    red1_q    <= red_i;
    green1_q  <= green_i;
    blue1_q   <= blue_i;
    vec1_q    <= vec1_d;
    grey1_q   <= (wd == 0);
    u_neg1_q  <= (u < 0);
    wd_pos1_q <= (wd > 0);
  end

  always_comb begin
    dev_r       = (mean1_q > red1_q) ? mean1_q - red1_q : red1_q - mean1_q;
    dev_g       = (mean1_q > green1_q) ? mean1_q - green1_q : green1_q - mean1_q;
    dev_b       = (mean1_q > blue1_q) ? mean1_q - blue1_q : blue1_q - mean1_q;
    dev_sum     = 10'(dev_r) + 10'(dev_g) + 10'(dev_b);
    spread_prod = 21'(dev_sum) * 21'd683;
    spread      = spread_prod[18:11];
  end

  always_ff @(posedge clk_i) begin
    pix_ok2_q <= (mean1_q >= min_bright_i) && (spread >= min_spread_i);
    grey2_q   <= grey1_q;
    u_neg2_q  <= u_neg1_q;
    wd_pos2_q <= wd_pos1_q;
    vec2_q    <= vec1_q;
  end

  assign vec_o         = vec2_q;
  assign side_o.valid  = valid2_q;
  assign side_o.pix_ok = pix_ok2_q;
  assign side_o.grey   = grey2_q;
  assign side_o.u_neg  = u_neg2_q;
  assign side_o.wd_pos = wd_pos2_q;

endmodule

[rtl/core/hcc_cordic_stage.sv]
// One pipeline stage holding two CORDIC vectoring iterations.
`timescale 1ns / 1ps
module hcc_cordic_stage import hcc_pkg::*; #(
  parameter int unsigned FirstStep = 0
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cordic_t vec_i,
  input  side_t   side_i,
  output cordic_t vec_o,
  output side_t   side_o
);

  cordic_t vec_d, vec_q;
  side_t   side_q;

  always_comb begin
    logic signed [28:0] dx;
    logic signed [28:0] dy;
    vec_d = vec_i;
    for (int k = 0; k < 2; k++) begin
      dx = vec_d.y >>> (FirstStep + k);
      dy = vec_d.x >>> (FirstStep + k);
      if (vec_d.y > 0) begin
        vec_d.x = vec_d.x + dx;
        vec_d.y = vec_d.y - dy;
        vec_d.z = vec_d.z + atan_q16(FirstStep + k);
      end else begin
        vec_d.x = vec_d.x - dx;
        vec_d.y = vec_d.y + dy;
        vec_d.z = vec_d.z - atan_q16(FirstStep + k);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q.valid <= 1'b0;
    end else begin
      vec_q  <= vec_d;
      side_q <= side_i;
    end
  end

  assign vec_o  = vec_q;
  assign side_o = side_q;

endmodule

[rtl/core/hcc_hue_scale.sv]
// Angle folding and scaling of the CORDIC angle to an 8-bit hue.
`timescale 1ns / 1ps
module hcc_hue_scale import hcc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic signed [19:0] z_i,
  input  side_t              side_i,
  output logic [7:0]         hue_o,
  output side_t              side_o
);

  logic signed [19:0] z_clamp;
  logic signed [19:0] ang;
  logic [18:0] ang1_q;
  logic [31:0] prod2;
  logic [15:0] q2_q;
  logic [32:0] prod3;
  logic [8:0]  h3;
  logic [7:0]  hue3_q;
  side_t side1_q, side2_q, side3_q;

  always_comb begin
    z_clamp = z_i;
    if (side_i.wd_pos) begin
      if (z_i < 0) z_clamp = '0;
      if (z_i > PiQ16) z_clamp = PiQ16;
    end else begin
      if (z_i > 0) z_clamp = '0;
      if (z_i < -PiQ16) z_clamp = -PiQ16;
    end
    if (side_i.grey) begin
      ang = side_i.u_neg ? PiQ16 : '0;
    end else begin
      ang = (z_clamp < 0) ? z_clamp + TwoPiQ16 : z_clamp;
    end
  end

  assign prod2 = 32'(ang1_q) * 32'd6400;
  assign prod3 = 33'(q2_q) * 33'd106862;
  assign h3    = prod3[32:24];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side1_q.valid <= 1'b0;
      side2_q.valid <= 1'b0;
      side3_q.valid <= 1'b0;
    end else begin
      ang1_q  <= ang[18:0];
      side1_q <= side_i;
      q2_q    <= prod2[31:16];
      side2_q <= side1_q;
      hue3_q  <= h3[8] ? 8'd255 : h3[7:0];
      side3_q <= side2_q;
    end
  end

  assign hue_o  = hue3_q;
  assign side_o = side3_q;

endmodule

[rtl/core/hcc_match.sv]
// Output stage: target hue matching by priority and result registers.
`timescale 1ns / 1ps
module hcc_match import hcc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] hue_i,
  input  side_t      side_i,
  input  match_cfg_t cfg_i,
  output logic       valid_o,
  output logic [2:0] color_class_o,
  output logic [7:0] hue_value_o,
  output logic       hue_valid_o
);

  function automatic logic near(input logic [7:0] target, input logic [7:0] hue,
                                input logic [7:0] radius);
    logic [7:0] d;
    logic [8:0] e;
    logic [8:0] m;
    d = (target > hue) ? target - hue : hue - target;
    e = 9'd256 - 9'(d);
    m = (9'(d) < e) ? 9'(d) : e;
    return m <= 9'(radius);
  endfunction

  color_class_e cls_d;
  logic         valid_q, hue_valid_q;
  logic [2:0]   cls_q;
  logic [7:0]   hue_q;

  always_comb begin
    if (near(cfg_i.target_red, hue_i, cfg_i.radius)) begin
      cls_d = ClassRed;
    end else if (near(cfg_i.target_green, hue_i, cfg_i.radius)) begin
      cls_d = ClassGreen;
    end else if (near(cfg_i.target_blue, hue_i, cfg_i.radius)) begin
      cls_d = ClassBlue;
    end else if (near(cfg_i.target_yellow, hue_i, cfg_i.radius)) begin
      cls_d = ClassYellow;
    end else begin
      cls_d = ClassNone;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= side_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    hue_valid_q <= side_i.pix_ok;
    cls_q       <= side_i.pix_ok ? cls_d : ClassNone;
    hue_q       <= side_i.pix_ok ? hue_i : 8'd0;
  end

  assign valid_o       = valid_q;
  assign color_class_o = cls_q;
  assign hue_value_o   = hue_q;
  assign hue_valid_o   = hue_valid_q;

endmodule

[rtl/core/hue_color_classifier_core.sv]
// Top level of the hue color classifier core.
`timescale 1ns / 1ps
// Classifies one RGB pixel per clock. A pixel is taken whenever start_i is high
// (busy_o stays low) and its result leaves the pipeline for exactly one cycle with
// result_valid_o high; the receiver cannot stall, so results must be taken as they
// come. The pipeline holds the sixteen CORDIC iterations, two per stage, plus two
// front stages and four for hue scaling and matching. Configuration registers are
// written via cfg_we_i, by the user only while no pixel is in flight; not enforced.
`include "hue_color_classifier_core_macros.svh"
module hue_color_classifier_core import hcc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [7:0] red_level_i,
  input  logic [7:0] green_level_i,
  input  logic [7:0] blue_level_i,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_addr_i,
  input  logic [7:0] cfg_wdata_i,
  output logic       result_valid_o,
  output logic [2:0] color_class_o,
  output logic [7:0] hue_value_o,
  output logic       hue_valid_o
);

  logic [7:0] tgt_red_q, tgt_green_q, tgt_blue_q, tgt_yellow_q;
  logic [7:0] radius_q, min_bright_q, min_spread_q;
  match_cfg_t match_cfg;

  cordic_t vec   [CordicStages+1];
  side_t   side  [CordicStages+1];
  logic [7:0] hue;
  side_t      hue_side;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_red_q    <= 8'd0;
      tgt_green_q  <= 8'd85;
      tgt_blue_q   <= 8'd170;
      tgt_yellow_q <= 8'd43;
      radius_q     <= 8'd10;
      min_bright_q <= 8'd30;
      min_spread_q <= 8'd10;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        RegTargetRed:    tgt_red_q    <= cfg_wdata_i;
        RegTargetGreen:  tgt_green_q  <= cfg_wdata_i;
        RegTargetBlue:   tgt_blue_q   <= cfg_wdata_i;
        RegTargetYellow: tgt_yellow_q <= cfg_wdata_i;
        RegHueRadius:    radius_q     <= cfg_wdata_i;
        RegMinBright:    min_bright_q <= cfg_wdata_i;
        RegMinSpread:    min_spread_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign match_cfg.target_red    = tgt_red_q;
  assign match_cfg.target_green  = tgt_green_q;
  assign match_cfg.target_blue   = tgt_blue_q;
  assign match_cfg.target_yellow = tgt_yellow_q;
  assign match_cfg.radius        = radius_q;

  hcc_prep u_prep (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (start_i & ~busy_o),
    .red_i        (red_level_i),
    .green_i      (green_level_i),
    .blue_i       (blue_level_i),
    .min_bright_i (min_bright_q),
    .min_spread_i (min_spread_q),
    .vec_o        (vec[0]),
    .side_o       (side[0])
  );

  for (genvar s = 0; s < CordicStages; s++) begin : g_cordic
    hcc_cordic_stage #(
      .FirstStep (2 * s)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vec_i  (vec[s]),
      .side_i (side[s]),
      .vec_o  (vec[s+1]),
      .side_o (side[s+1])
    );
  end

  hcc_hue_scale u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .z_i    (vec[CordicStages].z),
    .side_i (side[CordicStages]),
    .hue_o  (hue),
    .side_o (hue_side)
  );

  hcc_match u_match (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .hue_i         (hue),
    .side_i        (hue_side),
    .cfg_i         (match_cfg),
    .valid_o       (result_valid_o),
    .color_class_o (color_class_o),
    .hue_value_o   (hue_value_o),
    .hue_valid_o   (hue_valid_o)
  );

  `HCC_ASSERT_IMP(a_result_follows_start, result_valid_o, $past(start_i, Latency),
                  "result beat without a pixel accepted at the pipeline latency")
  `HCC_ASSERT_IMP(a_invalid_clears_fields, result_valid_o && !hue_valid_o,
                  color_class_o == ClassNone && hue_value_o == 8'd0,
                  "invalid pixel carries a class or a hue")
  `HCC_ASSERT_IMP(a_class_needs_valid, color_class_o != ClassNone, hue_valid_o,
                  "class given for an invalid pixel")
  `HCC_ASSERT_IMP(a_class_range, result_valid_o, color_class_o <= ClassYellow,
                  "class code out of range")
  `HCC_ASSERT_ALWAYS(a_never_busy, !busy_o, "busy raised on a pipeline that always accepts")

endmodule
